// ===== rtl/mus_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mus_pkg;

	// One input beat: a string byte and its end-of-string mark.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       string_end;
	} out_t;

	localparam logic [7:0] REPLACEMENT = 8'h3F;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_TAG    = 8'h80;
	localparam logic [3:0] LEAD2_HI    = 4'hE;
	localparam logic [3:0] BAD_HI      = 4'hF;

	// Held byte count codes; a count of three is treated like HELD_BOTH.
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_LEAD = 2'd1;
	localparam logic [1:0] HELD_BOTH = 2'd2;

	// Results caused by one input beat at most.
	localparam logic [1:0] MAX_RESULTS = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/modified_utf8_sanitizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    mus_pkg::in_t  (in_byte, in_last)
// out      out  out_valid / out_ready  mus_pkg::out_t (out_byte, run_end, string_end)
//
// Each input beat is decoded in the cycle it is accepted and its 0..3 results are
// written into a three-entry result shift buffer. Results leave one per cycle
// while out_ready is high, through the single output port; a new byte is taken
// only once the results of the previous one have drained.
// in_ready is high when the buffer is empty or its last entry leaves this cycle.
// arst_n clears the held sequence and empties the buffer.

module modified_utf8_sanitizer_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire mus_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output mus_pkg::out_t      out_data
);

	// Bytes produced by one input beat, in order.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      n;
	} res_buf_t;

	// Append a byte; anything past three results is dropped.
	function automatic res_buf_t push(input res_buf_t rb, input logic [7:0] b);
		res_buf_t r;
		r = rb;
		if (r.n != mus_pkg::MAX_RESULTS) begin
			r.bytes[r.n] = b;
			r.n          = r.n + 2'd1;
		end
		return r;
	endfunction

	// Held sequence state
	logic [7:0] held_lead_q;
	logic [7:0] held_cont_q;
	logic [1:0] held_count_q;
	logic       needs_two_q;

	// Result buffer: entry 0 is the head shown on the output
	mus_pkg::out_t res_q [3];
	logic [1:0]    res_cnt_q;

	// Next state from the decode
	logic [7:0] lead_d;
	logic [7:0] cont_d;
	logic [1:0] count_d;
	logic       two_d;
	res_buf_t   rb;

	logic [7:0] b;
	logic       last;
	logic       is_cont;
	logic       do_fresh;
	logic       in_acc;
	logic       out_pop;

	assign b    = in_data.in_byte;
	assign last = in_data.in_last;

	assign out_valid = (res_cnt_q != 2'd0);
	assign out_data  = res_q[0];
	assign out_pop   = out_valid && out_ready;
	// Take a new beat when the buffer is (or is about to be) empty.
	assign in_ready  = (res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && out_ready);
	assign in_acc    = in_valid && in_ready;

	assign is_cont = ((b & mus_pkg::CONT_MASK) == mus_pkg::CONT_TAG);

	// Decode one byte against the held sequence
	always_comb begin
		lead_d   = held_lead_q;
		cont_d   = held_cont_q;
		count_d  = held_count_q;
		two_d    = needs_two_q;
		rb       = '0;
		do_fresh = 1'b0;

		if (held_count_q == mus_pkg::HELD_NONE) begin
			do_fresh = 1'b1;
		end else if (is_cont) begin
			if ((held_count_q == mus_pkg::HELD_LEAD) && needs_two_q) begin
				cont_d  = b;
				count_d = mus_pkg::HELD_BOTH;
			end else begin
				// sequence complete: release it unchanged
				rb = push(rb, held_lead_q);
				if (held_count_q >= mus_pkg::HELD_BOTH) begin
					rb = push(rb, held_cont_q);
				end
				rb      = push(rb, b);
				lead_d  = '0;
				cont_d  = '0;
				count_d = mus_pkg::HELD_NONE;
				two_d   = 1'b0;
			end
		end else begin
			// early non-continuation byte: drop the pending sequence, re-examine b
			rb = push(rb, mus_pkg::REPLACEMENT);
			if (held_count_q >= mus_pkg::HELD_BOTH) begin
				rb = push(rb, mus_pkg::REPLACEMENT);
			end
			lead_d   = '0;
			cont_d   = '0;
			count_d  = mus_pkg::HELD_NONE;
			two_d    = 1'b0;
			do_fresh = 1'b1;
		end

		if (do_fresh) begin
			if (!b[7]) begin
				rb = push(rb, b);
			end else if (b[7:6] == 2'b11 && b[5:4] != 2'b11) begin
				// 110x or 1110 lead: start holding
				lead_d  = b;
				count_d = mus_pkg::HELD_LEAD;
				two_d   = (b[7:4] == mus_pkg::LEAD2_HI);
			end else begin
				// stray continuation or 1111 lead
				rb = push(rb, mus_pkg::REPLACEMENT);
			end
		end

		// end of string flushes whatever is still pending
		if (last && (count_d != mus_pkg::HELD_NONE)) begin
			rb = push(rb, mus_pkg::REPLACEMENT);
			if (count_d >= mus_pkg::HELD_BOTH) begin
				rb = push(rb, mus_pkg::REPLACEMENT);
			end
			lead_d  = '0;
			cont_d  = '0;
			count_d = mus_pkg::HELD_NONE;
			two_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lead_q  <= '0;
			held_cont_q  <= '0;
			held_count_q <= mus_pkg::HELD_NONE;
			needs_two_q  <= 1'b0;
		end else if (in_acc) begin
			held_lead_q  <= lead_d;
			held_cont_q  <= cont_d;
			held_count_q <= count_d;
			needs_two_q  <= two_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
		end else if (in_acc) begin
			res_cnt_q <= rb.n;
		end else if (out_pop) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	// Payload of the buffer needs no reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < 3; i++) begin
				res_q[i].out_byte   <= rb.bytes[i];
				res_q[i].run_end    <= (rb.n == 2'(i + 1));
				res_q[i].string_end <= (rb.n == 2'(i + 1)) && last;
			end
		end else if (out_pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mus_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mus_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire mus_pkg::in_t  in_data,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire mus_pkg::out_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// string end only on the last result of a beat
	a_send_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.string_end |-> out_data.run_end)
		else $error("string_end without run_end");

	// no new beat while a result is stalled
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken over a stalled result");

	// an empty output side always takes input
	a_idle_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("idle block not ready");

	// a beat with in_last always causes a result next cycle
	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.in_last |=> out_valid)
		else $error("final byte produced no result");

endmodule

bind modified_utf8_sanitizer_core mus_checker u_mus_checker (.*);

`default_nettype wire
